/* sv/astc_pkg.sv */
package astc_pkg;

  localparam int unsigned IMAGE_COLUMNS = 80;
  localparam int unsigned DUTY_LIMIT = 800;
  localparam int unsigned CFG_INDEX_W = 1;

  localparam logic [7:0] CEILING_RESET = 8'd150;
  localparam logic [7:0] FLOOR_RESET = 8'd90;
  localparam logic [7:0] GOAL_RESET = 8'd120;
  localparam logic [9:0] DRIVE_RESET = 10'd300;

  localparam logic [6:0] ROWS_RESET = 7'(IMAGE_COLUMNS);
  localparam logic [6:0] ROWS_FULL = 7'(IMAGE_COLUMNS - 5);
  localparam logic [6:0] ROWS_SHORT = 7'(IMAGE_COLUMNS / 2);

  localparam logic [16:0] CALM_Q4 = 17'd112;
  localparam logic [16:0] SHARP_Q4 = 17'd640;

  localparam logic [9:0] DUTY_MAX = 10'(DUTY_LIMIT);
  localparam logic signed [12:0] BRAKE_LIMIT = -13'sd10;

  // Reciprocals scaled by 2**16 for exact division of the bounded magnitudes.
  localparam logic [13:0] RECIP_5 = 14'd13108;
  localparam logic [15:0] RECIP_3 = 16'd21846;

  typedef enum logic [CFG_INDEX_W-1:0] {
    CFG_SPEED_CEILING = 1'b0,
    CFG_SPEED_FLOOR   = 1'b1
  } astc_cfg_index_t;

  typedef struct packed {
    logic [6:0]         track_rows;
    logic signed [15:0] steer_error;
    logic signed [11:0] wheel_speed;
    logic               halt;
  } astc_sample_t;

  typedef struct packed {
    logic [7:0] speed_ceiling;
    logic [7:0] speed_floor;
  } astc_limits_t;

endpackage

/* sv/astc_if.sv */
interface astc_sample_if;
  logic               valid;
  logic               ready;
  logic [6:0]         track_rows;
  logic signed [15:0] steer_error;
  logic signed [11:0] wheel_speed;
  logic               halt;

  modport source (output valid, output track_rows, output steer_error,
                  output wheel_speed, output halt, input ready);
  modport sink (input valid, input track_rows, input steer_error,
                input wheel_speed, input halt, output ready);
endinterface

interface astc_result_if;
  logic       valid;
  logic       ready;
  logic [9:0] motor_duty;
  logic       forward;
  logic [7:0] speed_goal;

  modport source (output valid, output motor_duty, output forward,
                  output speed_goal, input ready);
  modport sink (input valid, input motor_duty, input forward,
                input speed_goal, output ready);
endinterface

interface astc_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [astc_pkg::CFG_INDEX_W-1:0]   index;
  logic [7:0]                         data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* sv/adaptive_speed_target_controller_top.sv */
// One item per cycle while result.ready holds; a stall on the result side holds the pipe.
// The input, goal and output registers form a three-stage pipe.
// The speed goal loop closes in the first stage and the motor loop in the second.
// Reset is synchronous and active high: it empties the pipe and restores the limits,
// the steering, row and goal history, the speed error and the drive level.
module adaptive_speed_target_controller_top (
  input  logic               clk,
  input  logic               rst,
  astc_sample_if.sink        sample,
  astc_result_if.source      result,
  astc_cfg_if.sink           cfg
);

  astc_pkg::astc_limits_t limits;

  logic                   a_valid;
  astc_pkg::astc_sample_t a_item;
  logic                   b_valid;
  logic [7:0]             b_goal;
  logic signed [11:0]     b_wheel;
  logic                   o_valid;
  logic [9:0]             o_duty;
  logic                   o_forward;
  logic [7:0]             o_goal;

  logic                   o_free;
  logic                   b_free;
  logic                   a_free;
  logic                   move_a;
  logic                   move_b;
  logic [7:0]             goal;
  logic [9:0]             duty;
  logic                   forward;

  assign o_free = !o_valid || result.ready;
  assign move_b = b_valid && o_free;
  assign b_free = !b_valid || o_free;
  assign move_a = a_valid && b_free;
  assign a_free = !a_valid || b_free;

  assign sample.ready = a_free;
  assign cfg.ready = 1'b1;

  assign result.valid = o_valid;
  assign result.motor_duty = o_duty;
  assign result.forward = o_forward;
  assign result.speed_goal = o_goal;

  astc_goal u_goal (
    .clk     (clk),
    .rst     (rst),
    .sample  (a_item),
    .limits  (limits),
    .advance (move_a),
    .goal    (goal)
  );

  astc_motor u_motor (
    .clk     (clk),
    .rst     (rst),
    .goal    (b_goal),
    .wheel   (b_wheel),
    .advance (move_b),
    .duty    (duty),
    .forward (forward)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      limits.speed_ceiling <= astc_pkg::CEILING_RESET;
      limits.speed_floor <= astc_pkg::FLOOR_RESET;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        astc_pkg::CFG_SPEED_CEILING: begin
          limits.speed_ceiling <= cfg.data;
        end
        astc_pkg::CFG_SPEED_FLOOR: begin
          limits.speed_floor <= cfg.data;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      o_valid <= 1'b0;
    end else begin
      if (a_free) begin
        a_valid <= sample.valid;
      end
      if (b_free) begin
        b_valid <= move_a;
      end
      if (o_free) begin
        o_valid <= move_b;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (sample.valid && a_free) begin
      a_item.track_rows <= sample.track_rows;
      a_item.steer_error <= sample.steer_error;
      a_item.wheel_speed <= sample.wheel_speed;
      a_item.halt <= sample.halt;
    end
    if (move_a) begin
      b_goal <= goal;
      b_wheel <= a_item.wheel_speed;
    end
    if (move_b) begin
      o_duty <= duty;
      o_forward <= forward;
      o_goal <= b_goal;
    end
  end

endmodule

/* sv/astc_goal.sv */
module astc_goal (
  input  logic                   clk,
  input  logic                   rst,
  input  astc_pkg::astc_sample_t sample,
  input  astc_pkg::astc_limits_t limits,
  input  logic                   advance,
  output logic [7:0]             goal
);

  logic [6:0]         prev_rows;
  logic signed [15:0] prev_steer;
  logic [7:0]         prev_goal;

  logic signed [16:0] steer_now;
  logic signed [16:0] steer_old;
  logic [16:0]        a_now;
  logic [16:0]        a_old;
  logic signed [5:0]  bonus;
  logic signed [20:0] sum;
  logic [20:0]        sum_mag;
  logic [27:0]        quot_prod;
  logic [10:0]        quot;
  logic signed [11:0] target;
  logic [7:0]         goal_calc;

  always_comb begin
    steer_now = 17'(sample.steer_error);
    steer_old = 17'(prev_steer);
    a_now = steer_now[16] ? 17'(-steer_now) : 17'(steer_now);
    a_old = steer_old[16] ? 17'(-steer_old) : 17'(steer_old);

    bonus = 6'sd0;
    if (a_now <= astc_pkg::CALM_Q4 && a_old <= astc_pkg::CALM_Q4) begin
      bonus = bonus + 6'sd10;
    end
    if (sample.track_rows > astc_pkg::ROWS_FULL && prev_rows > astc_pkg::ROWS_FULL) begin
      bonus = bonus + 6'sd5;
    end
    if (a_now >= astc_pkg::SHARP_Q4 && a_old > astc_pkg::SHARP_Q4) begin
      bonus = bonus - 6'sd10;
    end
    if (sample.track_rows < astc_pkg::ROWS_SHORT && prev_rows < astc_pkg::ROWS_SHORT) begin
      bonus = bonus - 6'sd5;
    end

    // The sum is kept in units of 1/160 of a speed step.
    sum = 21'sd160 * $signed({13'd0, prev_goal})
        + 21'sd7 * ($signed({4'd0, a_old}) - $signed({4'd0, a_now}))
        + 21'sd80 * ($signed({14'd0, sample.track_rows}) - $signed({14'd0, prev_rows}))
        + 21'sd160 * 21'(bonus);

    // Divide the magnitude by 32 with a shift and by 5 with a reciprocal.
    sum_mag = sum[20] ? 21'(-sum) : 21'(sum);
    quot_prod = 28'(sum_mag[18:5]) * 28'(astc_pkg::RECIP_5);
    quot = quot_prod[26:16];
    target = sum[20] ? -$signed({1'b0, quot}) : $signed({1'b0, quot});

    if (target > $signed({4'd0, limits.speed_ceiling})) begin
      target = $signed({4'd0, limits.speed_ceiling});
    end
    if (target < $signed({4'd0, limits.speed_floor})) begin
      target = $signed({4'd0, limits.speed_floor});
    end
    goal_calc = target[7:0];

    goal = sample.halt ? 8'd0 : goal_calc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_rows <= astc_pkg::ROWS_RESET;
      prev_steer <= 16'sd0;
      prev_goal <= astc_pkg::GOAL_RESET;
    end else if (advance && !sample.halt) begin
      prev_rows <= sample.track_rows;
      prev_steer <= sample.steer_error;
      prev_goal <= goal_calc;
    end
  end

endmodule

/* sv/astc_motor.sv */
module astc_motor (
  input  logic               clk,
  input  logic               rst,
  input  logic [7:0]         goal,
  input  logic signed [11:0] wheel,
  input  logic               advance,
  output logic [9:0]         duty,
  output logic               forward
);

  logic signed [12:0] prev_err;
  logic [9:0]         drive_level;

  logic signed [12:0] err;
  logic [11:0]        err_abs;
  logic [30:0]        prop_prod;
  logic [12:0]        prop_mag;
  logic signed [17:0] prop;
  logic signed [17:0] deriv;
  logic signed [17:0] drive;
  logic [17:0]        drive_mag;

  always_comb begin
    err = $signed({5'd0, goal}) - 13'(wheel);
    err_abs = err[12] ? 12'(-err) : err[11:0];

    // err * 200 / 75 equals err * 8 / 3, truncated toward zero.
    prop_prod = 31'({err_abs, 3'b000}) * 31'(astc_pkg::RECIP_3);
    prop_mag = prop_prod[28:16];
    prop = err[12] ? -$signed({5'd0, prop_mag}) : $signed({5'd0, prop_mag});

    deriv = (18'(err) - 18'(prev_err)) * 18'sd8;
    drive = $signed({8'd0, drive_level}) + prop + deriv;

    if (err < astc_pkg::BRAKE_LIMIT) begin
      drive = 18'(err) * 18'sd7;
    end

    forward = !drive[17];
    drive_mag = drive[17] ? 18'(-drive) : 18'(drive);
    duty = (drive_mag > 18'(astc_pkg::DUTY_MAX)) ? astc_pkg::DUTY_MAX : drive_mag[9:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_err <= 13'sd0;
      drive_level <= astc_pkg::DRIVE_RESET;
    end else if (advance) begin
      prev_err <= err;
      drive_level <= duty;
    end
  end

endmodule

/* tb/speed_goal_checker.sv */
`timescale 1ns / 100ps

module speed_goal_checker
  import astc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  astc_sample_if      sample,
  astc_result_if      result,
  astc_cfg_if         cfg,
  output int unsigned outstanding,
  output int unsigned mismatches
);

  localparam int CALM_MAG   = 112;
  localparam int SHARP_MAG  = 640;
  localparam int ROWS_LONG  = int'(IMAGE_COLUMNS) - 5;
  localparam int ROWS_CLOSE = int'(IMAGE_COLUMNS) / 2;
  localparam int BRAKE_ERR  = -10;
  localparam int DUTY_CAP   = int'(DUTY_LIMIT);

  typedef struct packed {
    logic [9:0] duty;
    logic       fwd;
    logic [7:0] goal;
  } motor_cmd_t;

  motor_cmd_t         motor_cmds[$];
  logic [7:0]         goal_ceiling;
  logic [7:0]         goal_floor;
  logic [6:0]         rows_hist;
  logic signed [15:0] steer_hist;
  logic [7:0]         goal_hist;
  logic signed [12:0] err_hist;
  logic [9:0]         drive_hist;

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    mismatches++;
  endtask

  // One control tick: new speed target, then the incremental motor loop.
  function automatic motor_cmd_t advance_tick(input logic [6:0] rows,
                                              input logic signed [15:0] steer,
                                              input logic signed [11:0] wheel,
                                              input logic stop);
    int now_mag;
    int old_mag;
    int bonus;
    int total;
    int goal;
    int err;
    int drive;
    motor_cmd_t cmd;
    now_mag = (steer < 0) ? -int'(steer) : int'(steer);
    old_mag = (steer_hist < 0) ? -int'(steer_hist) : int'(steer_hist);
    if (stop) begin
      goal = 0;
    end else begin
      bonus = 0;
      if (now_mag <= CALM_MAG && old_mag <= CALM_MAG) bonus += 10;
      if (int'(rows) > ROWS_LONG && int'(rows_hist) > ROWS_LONG) bonus += 5;
      if (now_mag >= SHARP_MAG && old_mag > SHARP_MAG) bonus -= 10;
      if (int'(rows) < ROWS_CLOSE && int'(rows_hist) < ROWS_CLOSE) bonus -= 5;
      total = 160 * int'(goal_hist) + 7 * (old_mag - now_mag)
            + 80 * (int'(rows) - int'(rows_hist)) + 160 * bonus;
      goal = total / 160;
      if (goal > int'(goal_ceiling)) goal = int'(goal_ceiling);
      if (goal < int'(goal_floor)) goal = int'(goal_floor);
      steer_hist = steer;
      rows_hist = rows;
      goal_hist = goal[7:0];
    end
    err = goal - int'(wheel);
    drive = int'(drive_hist) + (err * 200) / 75 + (err - int'(err_hist)) * 8;
    err_hist = err[12:0];
    if (err < BRAKE_ERR) drive = err * 7;
    cmd.fwd = 1'b1;
    if (drive < 0) begin
      drive = -drive;
      cmd.fwd = 1'b0;
    end
    if (drive > DUTY_CAP) drive = DUTY_CAP;
    drive_hist = drive[9:0];
    cmd.duty = drive[9:0];
    cmd.goal = goal[7:0];
    return cmd;
  endfunction

  always @(posedge clk) begin
    motor_cmd_t want;
    if (rst) begin
      motor_cmds.delete();
      goal_ceiling = CEILING_RESET;
      goal_floor = FLOOR_RESET;
      rows_hist = 7'(IMAGE_COLUMNS);
      steer_hist = '0;
      goal_hist = GOAL_RESET;
      err_hist = '0;
      drive_hist = DRIVE_RESET;
      mismatches = 0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (astc_cfg_index_t'(cfg.index))
          CFG_SPEED_CEILING: goal_ceiling = cfg.data;
          CFG_SPEED_FLOOR:   goal_floor = cfg.data;
          default: ;
        endcase
      end
      if (result.valid && result.ready) begin
        if (motor_cmds.size() == 0) begin
          report_mismatch($sformatf("unexpected result duty %0d forward %0d goal %0d",
                                    result.motor_duty, result.forward, result.speed_goal));
        end else begin
          want = motor_cmds.pop_front();
          if (result.motor_duty !== want.duty)
            report_mismatch($sformatf("motor_duty %0d, expected %0d",
                                      result.motor_duty, want.duty));
          if (result.forward !== want.fwd)
            report_mismatch($sformatf("forward %0d, expected %0d",
                                      result.forward, want.fwd));
          if (result.speed_goal !== want.goal)
            report_mismatch($sformatf("speed_goal %0d, expected %0d",
                                      result.speed_goal, want.goal));
        end
      end
      if (sample.valid && sample.ready) begin
        motor_cmds.push_back(advance_tick(sample.track_rows, sample.steer_error,
                                          sample.wheel_speed, sample.halt));
      end
    end
    outstanding <= motor_cmds.size();
  end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 100ps

module testbench;
  import astc_pkg::*;

  localparam int RANDOM_PHASES = 8;
  localparam int TICKS_PER_PHASE = 116;

  logic        clk;
  logic        rst;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned outstanding;
  int unsigned mismatches;

  astc_sample_if smp ();
  astc_result_if res ();
  astc_cfg_if    cfg_ch ();

  adaptive_speed_target_controller_top dut (
    .clk    (clk),
    .rst    (rst),
    .sample (smp),
    .result (res),
    .cfg    (cfg_ch)
  );

  speed_goal_checker goal_check (
    .clk         (clk),
    .rst         (rst),
    .sample      (smp),
    .result      (res),
    .cfg         (cfg_ch),
    .outstanding (outstanding),
    .mismatches  (mismatches)
  );

  // Rows, steering error, wheel speed, halt. The halted run near the end brakes
  // twice and then walks the motor loop down to a drive of exactly zero.
  astc_sample_t directed_ticks [20] = '{
    '{127, 0, 0, 0},
    '{127, 32767, 2047, 0},
    '{0, -32768, -2048, 0},
    '{0, 640, 100, 0},
    '{39, 641, 90, 0},
    '{40, -640, 95, 0},
    '{76, 112, 100, 0},
    '{76, -112, 100, 0},
    '{75, 113, 100, 0},
    '{127, 1, 105, 0},
    '{80, 0, 120, 0},
    '{127, 500, -2048, 1},
    '{0, -500, 2047, 1},
    '{10, 0, 11, 1},
    '{10, 0, 10, 1},
    '{10, 0, 10, 1},
    '{10, 0, 8, 1},
    '{10, 0, 7, 1},
    '{10, 0, 7, 1},
    '{127, 0, 0, 0}
  };

  logic [7:0] ceiling_list [5] = '{255, 100, 0, 255, 200};
  logic [7:0] floor_list [5] = '{0, 140, 0, 255, 60};

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    res.ready = 1'b0;
    forever begin
      @(posedge clk);
      res.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    #2_000_000;
    $display("adaptive_speed_target_controller_top verification failed");
    $finish;
  end

  task automatic send_tick(input astc_sample_t tick);
    while ($urandom_range(99) < send_idle_pct) begin
      smp.valid <= 1'b0;
      @(posedge clk);
    end
    smp.valid <= 1'b1;
    smp.track_rows <= tick.track_rows;
    smp.steer_error <= tick.steer_error;
    smp.wheel_speed <= tick.wheel_speed;
    smp.halt <= tick.halt;
    do @(posedge clk); while (!smp.ready);
  endtask

  task automatic random_tick();
    astc_sample_t tick;
    case ($urandom_range(3))
      0: tick.track_rows = 7'($urandom_range(127));
      1: tick.track_rows = 7'($urandom_range(85, 70));
      default: tick.track_rows = 7'($urandom_range(45, 30));
    endcase
    if ($urandom_range(3) == 0) tick.steer_error = 16'($urandom);
    else tick.steer_error = 16'(int'($urandom_range(1600)) - 800);
    if ($urandom_range(3) == 0) tick.wheel_speed = 12'($urandom);
    else tick.wheel_speed = 12'(int'($urandom_range(320)) - 40);
    tick.halt = ($urandom_range(9) == 0);
    send_tick(tick);
  endtask

  task automatic drain();
    smp.valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic set_limits(input logic [7:0] top_val, input logic [7:0] low_val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= CFG_SPEED_CEILING;
    cfg_ch.data <= top_val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.index <= CFG_SPEED_FLOOR;
    cfg_ch.data <= low_val;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    logic [7:0] top_val;
    logic [7:0] low_val;
    rst = 1'b1;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    smp.valid = 1'b0;
    smp.track_rows = '0;
    smp.steer_error = '0;
    smp.wheel_speed = '0;
    smp.halt = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CFG_SPEED_CEILING;
    cfg_ch.data = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_ticks[i]) send_tick(directed_ticks[i]);

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      drain();
      if (phase < 5) begin
        top_val = ceiling_list[phase];
        low_val = floor_list[phase];
      end else begin
        top_val = 8'($urandom_range(255));
        low_val = 8'($urandom_range(255));
      end
      set_limits(top_val, low_val);
      case (phase % 4)
        0: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct = 57;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct = 0;
          recv_stall_pct = 57;
        end
        default: begin
          send_idle_pct = 17;
          recv_stall_pct = 17;
        end
      endcase
      repeat (TICKS_PER_PHASE) begin
        if ($urandom_range(99) == 0) drain();
        random_tick();
      end
    end

    drain();
    repeat (4) @(posedge clk);
    if (mismatches == 0) begin
      $display("adaptive_speed_target_controller_top verification clean");
    end else begin
      $display("adaptive_speed_target_controller_top verification failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
sv/astc_pkg.sv
sv/astc_if.sv
sv/astc_goal.sv
sv/astc_motor.sv
sv/adaptive_speed_target_controller_top.sv
tb/speed_goal_checker.sv
tb/testbench.sv
